// ----- hw/rtl/modexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int BaseWidth = 32;
    localparam int ExpWidth  = 32;
    localparam int ModWidth  = 30;
    localparam int CntWidth  = 6;

    localparam logic [ModWidth-1:0] ModulusReset = 30'd1000000007;

    // operand lengths in bits for the shared multiplier
    localparam logic [CntWidth-1:0] LenBase = 6'd32;
    localparam logic [CntWidth-1:0] LenMod  = 6'd30;

    typedef struct packed {
        logic                 start;
        logic [BaseWidth-1:0] a;
        logic [ModWidth-1:0]  b;
        logic [CntWidth-1:0]  len;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic [ModWidth-1:0] result;
    } t_mul_rsp;

endpackage

// ----- hw/rtl/modexp_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_modmul
// Shared modular multiplier: interleaved shift-add with reduction, one bit of
// operand a per cycle, msb first. Operand b must not exceed the modulus.
// ----------------------------------------------------------------------------
module modexp_modmul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [modexp_pkg::ModWidth-1:0]   i_modulus,
    input  modexp_pkg::t_mul_req              i_req,
    output modexp_pkg::t_mul_rsp              o_rsp
);

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [modexp_pkg::CntWidth-1:0]    r_cnt, n_cnt;
    logic [modexp_pkg::BaseWidth-1:0]   r_a, n_a;
    logic [modexp_pkg::ModWidth-1:0]    r_b, n_b;
    logic [modexp_pkg::ModWidth-1:0]    r_r, n_r;

    logic [modexp_pkg::BaseWidth-1:0]   w_sum;
    logic [modexp_pkg::BaseWidth-1:0]   w_m1;
    logic [modexp_pkg::BaseWidth-1:0]   w_m2;
    logic [modexp_pkg::BaseWidth-1:0]   w_red;

    assign w_m1  = {2'b00, i_modulus};
    assign w_m2  = {1'b0, i_modulus, 1'b0};
    assign w_sum = {1'b0, r_r, 1'b0}
                 + (r_a[modexp_pkg::BaseWidth-1] ? {2'b00, r_b} : '0);

    always_comb begin
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_r    = r_r;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.len;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_r    = '0;
        end else if (r_busy) begin
            n_r   = w_red[modexp_pkg::ModWidth-1:0];
            n_a   = {r_a[modexp_pkg::BaseWidth-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_r   <= n_r;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

endmodule

// ----- hw/rtl/modexp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for right-to-left square-and-multiply over the shared multiplier.
// ----------------------------------------------------------------------------
module modexp_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [modexp_pkg::BaseWidth-1:0]   i_base,
    input  logic [modexp_pkg::BaseWidth-1:0]   i_exponent,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [modexp_pkg::ModWidth-1:0]    o_power,
    output modexp_pkg::t_mul_req               o_req,
    input  modexp_pkg::t_mul_rsp               i_rsp
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRed  = 3'd1;
    localparam logic [2:0] StMul  = 3'd2;
    localparam logic [2:0] StSqr  = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [modexp_pkg::ExpWidth-1:0]    r_exp, n_exp;
    logic [modexp_pkg::ModWidth-1:0]    r_acc, n_acc;
    logic [modexp_pkg::ModWidth-1:0]    r_b, n_b;
    logic                               r_start, n_start;
    logic [modexp_pkg::BaseWidth-1:0]   r_a_op, n_a_op;
    logic [modexp_pkg::ModWidth-1:0]    r_b_op, n_b_op;
    logic [modexp_pkg::CntWidth-1:0]    r_len, n_len;

    logic                               w_go;
    logic [modexp_pkg::ExpWidth-1:0]    w_e;
    logic [modexp_pkg::ModWidth-1:0]    w_bv;
    logic [modexp_pkg::ModWidth-1:0]    w_accv;

    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_acc   = r_acc;
        n_b     = r_b;
        n_start = 1'b0;
        n_a_op  = r_a_op;
        n_b_op  = r_b_op;
        n_len   = r_len;
        w_go    = 1'b0;
        w_e     = r_exp;
        w_bv    = r_b;
        w_accv  = r_acc;
        case (r_state)
            StIdle: begin
                if (i_valid) begin
                    n_exp   = i_exponent[modexp_pkg::ExpWidth-1:0];
                    n_acc   = {{(modexp_pkg::ModWidth-1){1'b0}}, 1'b1};
                    n_start = 1'b1;
                    n_a_op  = i_base;
                    n_b_op  = {{(modexp_pkg::ModWidth-1){1'b0}}, 1'b1};
                    n_len   = modexp_pkg::LenBase;
                    n_state = StRed;
                end
            end
            StRed: begin
                if (i_rsp.done) begin
                    n_b  = i_rsp.result;
                    w_go = 1'b1;
                    w_bv = i_rsp.result;
                end
            end
            StMul: begin
                if (i_rsp.done) begin
                    n_acc   = i_rsp.result;
                    n_start = 1'b1;
                    n_a_op  = {r_b, 2'b00};
                    n_b_op  = r_b;
                    n_len   = modexp_pkg::LenMod;
                    n_state = StSqr;
                end
            end
            StSqr: begin
                if (i_rsp.done) begin
                    n_b   = i_rsp.result;
                    n_exp = r_exp >> 1;
                    w_go  = 1'b1;
                    w_e   = r_exp >> 1;
                    w_bv  = i_rsp.result;
                end
            end
            StOut: begin
                if (i_ready) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase

        // next exponent bit
        if (w_go) begin
            if (w_e == '0) begin
                n_state = StOut;
            end else if (w_e[0]) begin
                n_start = 1'b1;
                n_a_op  = {w_accv, 2'b00};
                n_b_op  = w_bv;
                n_len   = modexp_pkg::LenMod;
                n_state = StMul;
            end else begin
                n_start = 1'b1;
                n_a_op  = {w_bv, 2'b00};
                n_b_op  = w_bv;
                n_len   = modexp_pkg::LenMod;
                n_state = StSqr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
        r_exp  <= n_exp;
        r_acc  <= n_acc;
        r_b    <= n_b;
        r_a_op <= n_a_op;
        r_b_op <= n_b_op;
        r_len  <= n_len;
    end

    assign o_ready     = (r_state == StIdle);
    assign o_valid     = (r_state == StOut);
    assign o_power     = r_acc;
    assign o_req.start = r_start;
    assign o_req.a     = r_a_op;
    assign o_req.b     = r_b_op;
    assign o_req.len   = r_len;

endmodule

// ----- hw/rtl/modular_exponentiation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Base to the exponent modulo a configured modulus, by square-and-multiply.
// ----------------------------------------------------------------------------
// One item at a time runs through a single shared modular multiplier that
// handles one operand bit per cycle. The base is first reduced; each exponent
// bit then costs a square plus a multiply when the bit is set, and scanning
// stops at the highest set bit. The input is not ready from acceptance until
// the result is taken. A modulus write of zero acts as a modulus of one.
module modular_exponentiation_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [modexp_pkg::ModWidth-1:0]    i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [modexp_pkg::BaseWidth-1:0]   i_base,
    input  logic [modexp_pkg::BaseWidth-1:0]   i_exponent,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [modexp_pkg::ModWidth-1:0]    o_power
);

    logic [modexp_pkg::ModWidth-1:0] r_modulus, n_modulus;
    modexp_pkg::t_mul_req            w_req;
    modexp_pkg::t_mul_rsp            w_rsp;

    always_comb begin
        n_modulus = r_modulus;
        if (i_cfg_we) begin
            n_modulus = (i_cfg_wdata == '0) ? {{(modexp_pkg::ModWidth-1){1'b0}}, 1'b1}
                                            : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= modexp_pkg::ModulusReset;
        end else begin
            r_modulus <= n_modulus;
        end
    end

    modexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_power    (o_power),
        .o_req      (w_req),
        .i_rsp      (w_rsp)
    );

    modexp_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (w_req),
        .o_rsp     (w_rsp)
    );

    // result is reduced, or the unreduced one for a zero exponent
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power < r_modulus) || (o_power == 1))
        else $error("power out of range");

    // busy after an accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready && !o_valid)
        else $error("ready after accept");

    // multiplier only reports while an item is in work
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> !o_ready && !o_valid)
        else $error("multiplier done while idle");

    // a start never lands while the result is shown
    a_no_start_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_req.start)
        else $error("multiplier started during output");

endmodule

// ----- sim/modular_exponentiation_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top_tb
// Self-checking bench for the square-and-multiply modular exponentiation block.
// ----------------------------------------------------------------------------
// Operands go in over a valid/ready channel. A scoreboard predicts base to the
// exponent under the current modulus and compares each power that comes out
// against the oldest prediction. The modulus is rewritten between phases while
// the block is drained: reset value, one, zero, the 30-bit maximum, small and
// random moduli. Both sides idle at random, and once the sink holds off for a
// long stretch so the input side stalls.
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;

    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles    = 4000;
    localparam int DrainCycles   = 64;

    typedef struct {
        logic [modexp_pkg::BaseWidth-1:0] base;
        logic [modexp_pkg::BaseWidth-1:0] exponent;
        logic [modexp_pkg::ModWidth-1:0]  power;
    } t_power_item;

    class modexp_scoreboard;
        logic [modexp_pkg::ModWidth-1:0] modulus;
        t_power_item                     expected_powers[$];
        int                              mismatch_count;
        int                              operand_count;
        int                              power_count;

        function new();
            modulus        = modexp_pkg::ModulusReset;
            mismatch_count = 0;
            operand_count  = 0;
            power_count    = 0;
        endfunction

        function logic [modexp_pkg::ModWidth-1:0] predict_power(
            logic [modexp_pkg::BaseWidth-1:0] base,
            logic [modexp_pkg::BaseWidth-1:0] exponent);
            longint unsigned m;
            longint unsigned b;
            longint unsigned acc;
            int              i;
            m   = (modulus == '0) ? 64'd1 : 64'(modulus);
            b   = 64'(base) % m;
            acc = 64'd1;
            for (i = 0; i < modexp_pkg::ExpWidth; i++) begin
                if ((exponent >> i) == '0) break;
                if (exponent[i]) acc = (acc * b) % m;
                b = (b * b) % m;
            end
            return acc[modexp_pkg::ModWidth-1:0];
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        function void note_operands(logic [modexp_pkg::BaseWidth-1:0] base,
                                    logic [modexp_pkg::BaseWidth-1:0] exponent);
            t_power_item item;
            item.base     = base;
            item.exponent = exponent;
            item.power    = predict_power(base, exponent);
            expected_powers.push_back(item);
            operand_count++;
        endfunction

        task check_power(logic [modexp_pkg::ModWidth-1:0] power);
            t_power_item item;
            if (expected_powers.size() == 0) begin
                report($sformatf("unexpected power %0d", power));
            end else begin
                item = expected_powers.pop_front();
                power_count++;
                if (power !== item.power)
                    report($sformatf("base %h exp %h mod %0d: power %0d, want %0d",
                                     item.base, item.exponent, modulus, power,
                                     item.power));
            end
        endtask
    endclass

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [modexp_pkg::ModWidth-1:0]  i_cfg_wdata = '0;
    logic                             i_valid     = 1'b0;
    logic                             o_ready;
    logic [modexp_pkg::BaseWidth-1:0] i_base      = '0;
    logic [modexp_pkg::BaseWidth-1:0] i_exponent  = '0;
    logic                             o_valid;
    logic                             i_ready     = 1'b0;
    logic [modexp_pkg::ModWidth-1:0]  o_power;

    modexp_scoreboard sb;
    bit               pressure_armed = 1'b0;
    bit               pressure_done  = 1'b0;
    int               stalled_cycles = 0;
    int               modulus_writes = 0;

    modular_exponentiation_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_power     (o_power)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 20);
        else return $urandom_range(50, 200);
    endfunction

    // monitor both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_operands(i_base, i_exponent);
            if (o_valid && i_ready) sb.check_power(o_power);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WatchdogLimit) begin
            $display("timeout: no handshake for %0d cycles", stalled_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // result sink with random stalls and one long hold-off
    initial begin : power_sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pressure_armed && !pressure_done) begin
                gap           = HoldCycles;
                pressure_done = 1'b1;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task drive_operands(logic [modexp_pkg::BaseWidth-1:0] base,
                        logic [modexp_pkg::BaseWidth-1:0] exponent, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_powers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_modulus(logic [modexp_pkg::ModWidth-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.modulus = value;
        modulus_writes++;
    endtask

    task run_random_phase(int count);
        logic [modexp_pkg::BaseWidth-1:0] base;
        logic [modexp_pkg::BaseWidth-1:0] exponent;
        int                               n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0: base = $urandom_range(0, 2);
                1: base = 32'hFFFF_FFFF - $urandom_range(0, 2);
                2: base = sb.modulus * $urandom_range(0, 3) + $urandom_range(0, 1);
                3: base = $urandom_range(0, sb.modulus);
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0: exponent = $urandom_range(0, 3);
                1, 2: exponent = $urandom >> $urandom_range(1, 31);
                3: exponent = 32'hFFFF_FFFF;
                default: exponent = $urandom;
            endcase
            drive_operands(base, exponent, pick_gap());
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus
        drive_operands(32'd0, 32'd0, 0);
        drive_operands(32'd0, 32'd1, 0);
        drive_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        drive_operands(32'd1, 32'hFFFF_FFFF, 0);
        drive_operands(32'd2, 32'h8000_0000, 2);
        drive_operands(32'd1000000007, 32'd5, 0);
        drive_operands(32'd1000000006, 32'd2, 0);
        drive_operands(32'hFFFF_FFFF, 32'd0, 3);
        drive_operands(32'd12345, 32'd1, 0);
        wait_drained();

        // modulus one
        write_modulus(30'd1);
        drive_operands(32'd5, 32'd0, 0);
        drive_operands(32'd5, 32'd3, 0);
        drive_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        wait_drained();

        // zero modulus acts as one
        write_modulus(30'd0);
        drive_operands(32'd0, 32'd0, 0);
        drive_operands(32'd7, 32'd1, 1);
        drive_operands(32'hFFFF_FFFF, 32'h8000_0001, 0);
        wait_drained();

        // widest modulus
        write_modulus(30'h3FFF_FFFF);
        drive_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        drive_operands(32'h3FFF_FFFE, 32'd2, 0);
        drive_operands(32'h3FFF_FFFF, 32'd3, 2);
        wait_drained();

        write_modulus(30'd2);
        drive_operands(32'd3, 32'hFFFF_FFFF, 0);
        drive_operands(32'hFFFF_FFFE, 32'd1, 0);
        wait_drained();

        // random part, long sink hold-off during the first phase
        write_modulus(modexp_pkg::ModulusReset);
        pressure_armed = 1'b1;
        run_random_phase(95);
        write_modulus(30'h3FFF_FFFF);
        run_random_phase(50);
        write_modulus(30'($urandom_range(1, 30'h3FFF_FFFF)));
        run_random_phase(40);
        write_modulus(30'($urandom_range(2, 100)));
        run_random_phase(40);
        write_modulus(30'($urandom_range(1, 30'h3FFF_FFFF)));
        run_random_phase(30);
        write_modulus(30'd1);
        run_random_phase(10);
        write_modulus(30'd0);
        run_random_phase(5);

        repeat (DrainCycles) @(posedge i_clk);
        if (sb.expected_powers.size() != 0)
            sb.report($sformatf("%0d powers never arrived", sb.expected_powers.size()));

        $display("run covered %0d operand items and %0d powers over %0d modulus writes",
                 sb.operand_count, sb.power_count, modulus_writes);
        $display("moduli: reset prime, one, zero, 30-bit max, two, small and random");
        if (sb.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_modmul.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation_top.sv
sim/modular_exponentiation_top_tb.sv
